@@ src/fcs_pkg.sv @@
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants for the circular-buffer saturating FIR unit.
// ----------------------------------------------------------------------------
package fcs_pkg;

   // Default filter length
   localparam int TAPS_DEFAULT = 256;

   // Width of one coefficient times one sample
   localparam int PROD_W = 32;

   // Transaction function codes
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_COEF   = 1'b1;

   // Clamp window, small-value window and output scaling
   localparam logic signed [31:0] CLAMP_HI    = 32'sh3FFF_FFFF;
   localparam logic signed [31:0] CLAMP_LO    = -32'sh4000_0000;
   localparam logic signed [31:0] SMALL_LIMIT = 32'sd1000;
   localparam int                 OUT_SHIFT   = 15;
   localparam logic [15:0]        COUNT_MAX   = 16'hFFFF;

   typedef struct packed {
      logic               func;
      logic signed [15:0] sample;
      logic [7:0]         coef_index;
      logic signed [15:0] coef_value;
   } fcs_req_type;

   typedef struct packed {
      logic signed [15:0] filtered;
      logic               clamped_high;
      logic               clamped_low;
      logic [15:0]        overflow_total;
      logic [15:0]        underflow_total;
   } fcs_rsp_type;

   // Strobes from the sequencer to the memory and MAC datapath
   typedef struct packed {
      logic hist_we;
      logic coef_we;
      logic rd_en;
      logic acc_clr;
   } fcs_ctl_type;

endpackage

@@ src/fcs_mac.sv @@
// ----------------------------------------------------------------------------
// fcs_mac
// History ring and coefficient memories with a registered multiply and a
// wide accumulator behind the synchronous read ports.
// ----------------------------------------------------------------------------
module fcs_mac
   import fcs_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  fcs_ctl_type                                ctl,
   input  logic [$clog2(TAPS)-1:0]                    hist_waddr,
   input  logic signed [15:0]                         hist_wdata,
   input  logic [$clog2(TAPS)-1:0]                    coef_waddr,
   input  logic signed [15:0]                         coef_wdata,
   input  logic [$clog2(TAPS)-1:0]                    hist_raddr,
   input  logic [$clog2(TAPS)-1:0]                    coef_raddr,
   output logic signed [PROD_W+$clog2(TAPS)-1:0]      acc,
   output logic                                       mac_idle
);

   localparam int TAP_W = $clog2(TAPS);
   localparam int ACC_W = PROD_W + TAP_W;

   logic signed [15:0]       hist_mem_ff [TAPS];
   logic signed [15:0]       coef_mem_ff [TAPS];
   logic signed [15:0]       hist_q_ff;
   logic signed [15:0]       coef_q_ff;
   logic                     rd_vld_ff;
   logic                     rd_vld_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     mul_vld_ff;
   logic                     mul_vld_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   always_ff @(posedge clock) begin
      if (ctl.hist_we) begin
         hist_mem_ff[hist_waddr] <= hist_wdata;
      end
      if (ctl.coef_we) begin
         coef_mem_ff[coef_waddr] <= coef_wdata;
      end
      if (ctl.rd_en) begin
         hist_q_ff <= hist_mem_ff[hist_raddr];
         coef_q_ff <= coef_mem_ff[coef_raddr];
      end
   end

   assign rd_vld_in  = ctl.rd_en;
   assign mul_vld_in = rd_vld_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= PROD_W'(coef_q_ff) * PROD_W'(hist_q_ff);
      end
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= mul_vld_in;
      end
   end

   assign acc      = acc_ff;
   assign mac_idle = !rd_vld_ff && !mul_vld_ff;

endmodule

@@ src/fcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcs_ctrl
// Sequencer: clearing pass after reset, coefficient writes, ring write and
// one tap read per cycle, hand-off of the finished sum.
// ----------------------------------------------------------------------------
module fcs_ctrl
   import fcs_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fcs_req_type             req_data,
   input  logic                    mac_idle,
   input  logic                    out_free,
   output fcs_ctl_type             ctl,
   output logic [$clog2(TAPS)-1:0] hist_waddr,
   output logic signed [15:0]      hist_wdata,
   output logic [$clog2(TAPS)-1:0] coef_waddr,
   output logic signed [15:0]      coef_wdata,
   output logic [$clog2(TAPS)-1:0] hist_raddr,
   output logic [$clog2(TAPS)-1:0] coef_raddr,
   output logic                    finish
);

   localparam int               TAP_W = $clog2(TAPS);
   localparam logic [TAP_W-1:0] LAST  = TAP_W'(TAPS - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic [TAP_W-1:0] clr_ptr_ff;
   logic [TAP_W-1:0] clr_ptr_in;
   logic [TAP_W-1:0] pos_ff;
   logic [TAP_W-1:0] pos_in;
   logic [TAP_W-1:0] tap_ff;
   logic [TAP_W-1:0] tap_in;
   logic [TAP_W-1:0] hptr_ff;
   logic [TAP_W-1:0] hptr_in;
   logic             coef_ok;

   assign coef_ok = (32'(req_data.coef_index) < TAPS);

   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      pos_in     = pos_ff;
      tap_in     = tap_ff;
      hptr_in    = hptr_ff;
      ctl        = '0;
      hist_waddr = pos_ff;
      hist_wdata = req_data.sample;
      coef_waddr = TAP_W'(req_data.coef_index);
      coef_wdata = req_data.coef_value;
      finish     = 1'b0;
      req_stall  = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.hist_we = 1'b1;
            ctl.coef_we = 1'b1;
            hist_waddr  = clr_ptr_ff;
            coef_waddr  = clr_ptr_ff;
            hist_wdata  = '0;
            coef_wdata  = '0;
            if (clr_ptr_ff == LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.func == FUNC_COEF) begin
                  // drop writes beyond the table
                  ctl.coef_we = coef_ok;
               end else begin
                  ctl.hist_we = 1'b1;
                  ctl.acc_clr = 1'b1;
                  tap_in      = '0;
                  hptr_in     = pos_ff;
                  pos_in      = (pos_ff == LAST) ? '0 : pos_ff + 1'b1;
                  state_in    = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            ctl.rd_en = 1'b1;
            tap_in    = tap_ff + 1'b1;
            // walk the ring backwards from the newest sample
            hptr_in   = (hptr_ff == '0) ? LAST : hptr_ff - 1'b1;
            if (tap_ff == LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the MAC pipe drains and the output register is free
            if (mac_idle && out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign hist_raddr = hptr_ff;
   assign coef_raddr = tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ptr_ff <= '0;
         pos_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      hptr_ff <= hptr_in;
   end

endmodule

@@ src/fcs_result.sv @@
// ----------------------------------------------------------------------------
// fcs_result
// Clamp, small-value passthrough or scaling, saturating clamp counters and
// the output register.
// ----------------------------------------------------------------------------
module fcs_result
   import fcs_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [PROD_W+$clog2(TAPS)-1:0] acc,
   input  logic                                  finish,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output fcs_rsp_type                           rsp_data,
   output logic                                  out_free
);

   localparam int ACC_W = PROD_W + $clog2(TAPS);

   localparam logic signed [ACC_W-1:0] HI_LIM = ACC_W'(CLAMP_HI);
   localparam logic signed [ACC_W-1:0] LO_LIM = ACC_W'(CLAMP_LO);

   logic                     over;
   logic                     under;
   logic signed [31:0]       clamped;
   logic signed [31:0]       scaled;
   logic signed [15:0]       filtered;
   logic [15:0]              ovf_cnt_ff;
   logic [15:0]              ovf_cnt_in;
   logic [15:0]              unf_cnt_ff;
   logic [15:0]              unf_cnt_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   fcs_rsp_type              rsp_data_ff;
   fcs_rsp_type              rsp_data_in;

   always_comb begin
      over    = (acc > HI_LIM);
      under   = (acc < LO_LIM);
      clamped = over ? CLAMP_HI : (under ? CLAMP_LO : acc[31:0]);
      scaled  = clamped >>> OUT_SHIFT;
      if ((clamped < SMALL_LIMIT) && (clamped > -SMALL_LIMIT)) begin
         filtered = clamped[15:0];
      end else begin
         filtered = scaled[15:0];
      end
   end

   always_comb begin
      ovf_cnt_in = ovf_cnt_ff;
      unf_cnt_in = unf_cnt_ff;
      if (finish && over && (ovf_cnt_ff != COUNT_MAX)) begin
         ovf_cnt_in = ovf_cnt_ff + 1'b1;
      end
      if (finish && under && (unf_cnt_ff != COUNT_MAX)) begin
         unf_cnt_in = unf_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_data_in                 = rsp_data_ff;
      rsp_valid_in                = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.filtered        = filtered;
         rsp_data_in.clamped_high    = over;
         rsp_data_in.clamped_low     = under;
         rsp_data_in.overflow_total  = ovf_cnt_in;
         rsp_data_in.underflow_total = unf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ovf_cnt_ff   <= '0;
         unf_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ovf_cnt_ff   <= ovf_cnt_in;
         unf_cnt_ff   <= unf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

@@ src/fir_filter_circular_saturating_unit.sv @@
// ----------------------------------------------------------------------------
// fir_filter_circular_saturating_unit
// Direct-form FIR over a circular history ring with a wide accumulator,
// clamp to [-2^30, 2^30-1], saturating clamp counters and output scaling.
//
//   port group  direction  payload        accepted when
//   req_*       in         fcs_req_type   req_valid && !req_stall
//   rsp_*       out        fcs_rsp_type   rsp_valid && !rsp_stall
//
// After a sample transaction is accepted, req_stall stays high until the
// next one can be taken: one memory read of each table per tap, then the
// multiply and accumulate registers drain. A coefficient transaction does
// not hold off the next request. After reset both memories are cleared,
// one entry a cycle; req_stall stays high meanwhile. A stalled result stays
// in the output register while the next sample is already being filtered.
// ----------------------------------------------------------------------------
module fir_filter_circular_saturating_unit
   import fcs_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fcs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fcs_rsp_type rsp_data
);

   localparam int TAP_W = $clog2(TAPS);
   localparam int ACC_W = PROD_W + TAP_W;

   fcs_ctl_type              ctl;
   logic [TAP_W-1:0]         hist_waddr;
   logic signed [15:0]       hist_wdata;
   logic [TAP_W-1:0]         coef_waddr;
   logic signed [15:0]       coef_wdata;
   logic [TAP_W-1:0]         hist_raddr;
   logic [TAP_W-1:0]         coef_raddr;
   logic signed [ACC_W-1:0]  acc;
   logic                     mac_idle;
   logic                     out_free;
   logic                     finish;

   fcs_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .mac_idle   (mac_idle),
      .out_free   (out_free),
      .ctl        (ctl),
      .hist_waddr (hist_waddr),
      .hist_wdata (hist_wdata),
      .coef_waddr (coef_waddr),
      .coef_wdata (coef_wdata),
      .hist_raddr (hist_raddr),
      .coef_raddr (coef_raddr),
      .finish     (finish)
   );

   fcs_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .hist_waddr (hist_waddr),
      .hist_wdata (hist_wdata),
      .coef_waddr (coef_waddr),
      .coef_wdata (coef_wdata),
      .hist_raddr (hist_raddr),
      .coef_raddr (coef_raddr),
      .acc        (acc),
      .mac_idle   (mac_idle)
   );

   fcs_result #(
      .TAPS (TAPS)
   ) u_result (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .finish    (finish),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .out_free  (out_free)
   );

endmodule

@@ src/fcs_checker.sv @@
// ----------------------------------------------------------------------------
// fcs_checker
// Port-level checks for the FIR unit, bound to the top level.
// ----------------------------------------------------------------------------
module fcs_checker
   import fcs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input fcs_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input fcs_rsp_type rsp_data
);

   // memories are being cleared straight after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("input not held off or result shown after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   a_high_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clamped_high |->
         rsp_data.filtered == 16'sh7FFF && rsp_data.overflow_total != 16'h0000
         && !rsp_data.clamped_low)
      else $error("upper clamp inconsistent");

   a_low_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clamped_low |->
         rsp_data.filtered == -16'sh8000 && rsp_data.underflow_total != 16'h0000)
      else $error("lower clamp inconsistent");

endmodule

bind fir_filter_circular_saturating_unit fcs_checker u_fcs_checker (.*);
